// File: hdl/fsif_pkg.sv
// package: request and result types and format constants for the float splitter
package fsif_pkg;

  localparam int unsigned SglMant = 23;
  localparam int unsigned DblMant = 52;
  localparam logic [10:0] SglBias = 11'h07F;
  localparam logic [10:0] DblBias = 11'h3FF;

  typedef struct packed {
    logic        req_type;
    logic [63:0] value_bits;
  } fsif_req_t;

  typedef struct packed {
    logic [63:0] integer_part;
    logic [63:0] fractional_part;
  } fsif_rsp_t;

  typedef struct packed {
    logic [63:0] v;
    logic        dbl;
    logic        pass_int;
    logic        pass_frac;
    logic        zero_rem;
    logic [63:0] rem;
    logic [63:0] mask;
    logic [11:0] e;
  } fsif_mid_t;

endpackage

// File: hdl/fsif_decode.sv
// decode stage: exponent classification and mantissa mask
module fsif_decode import fsif_pkg::*; (
  input  fsif_req_t req_i,
  output fsif_mid_t mid_o
);
  logic [63:0] v;
  logic [11:0] e;
  logic [5:0]  mb;
  logic [63:0] mask;

  always_comb begin
    mid_o = '0;
    if (req_i.req_type) begin
      v  = req_i.value_bits;
      e  = {1'b0, v[62:52]} - {1'b0, DblBias};
      mb = 6'(DblMant);
    end else begin
      v  = {32'd0, req_i.value_bits[31:0]};
      e  = {4'd0, v[30:23]} - {1'b0, SglBias};
      mb = 6'(SglMant);
    end
    mask = (64'd1 << (7'(mb) - 7'(e[6:0]))) - 64'd1;
    mid_o.v         = v;
    mid_o.dbl       = req_i.req_type;
    mid_o.e         = e;
    mid_o.pass_frac = e[11];
    mid_o.pass_int  = !e[11] && (e >= 12'(mb));
    mid_o.mask      = mask;
    mid_o.rem       = v & mask;
    mid_o.zero_rem  = ((v & mask) == 64'd0);
  end
endmodule

// File: hdl/fsif_norm.sv
// normalize stage: leading one search and fraction assembly
module fsif_norm import fsif_pkg::*; (
  input  fsif_mid_t mid_i,
  output fsif_rsp_t rsp_o
);
  logic [5:0]  p;
  logic [5:0]  mb;
  logic [11:0] biased;
  logic [63:0] shifted;
  logic [63:0] frac;

  always_comb begin
    p = '0;
    for (int i = 0; i < 64; i++) begin
      if (mid_i.rem[i]) p = 6'(i);
    end
    mb      = mid_i.dbl ? 6'(DblMant) : 6'(SglMant);
    biased  = 12'(p) + mid_i.e - 12'(mb) + (mid_i.dbl ? {1'b0, DblBias} : {1'b0, SglBias});
    shifted = mid_i.rem << (mb - p);
    if (mid_i.dbl) begin
      frac = {mid_i.v[63], biased[10:0], shifted[51:0]};
    end else begin
      frac = {32'd0, mid_i.v[31], biased[7:0], shifted[22:0]};
    end
    if (mid_i.pass_int || (!mid_i.pass_frac && mid_i.zero_rem)) begin
      rsp_o.integer_part    = mid_i.v;
      rsp_o.fractional_part = '0;
    end else if (mid_i.pass_frac) begin
      rsp_o.integer_part    = '0;
      rsp_o.fractional_part = mid_i.v;
    end else begin
      rsp_o.integer_part    = mid_i.v & ~mid_i.mask;
      rsp_o.fractional_part = frac;
    end
  end
endmodule

// File: hdl/float_split_integer_fraction.sv
// top level: registered float integer/fraction splitter
// One request is taken in every cycle; busy_o is always low. The request is held in
// req_q and the result in rsp_q; done_o follows start_i through vld_q and done_q and
// is high for one cycle; the receiver cannot stall it. The input register and the
// result register sit around the decode and normalize logic.
module float_split_integer_fraction import fsif_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  fsif_req_t req_i,
  output logic      busy_o,
  output logic      done_o,
  output fsif_rsp_t rsp_o
);
  fsif_req_t req_q;
  logic      vld_q, done_q;
  fsif_mid_t mid;
  fsif_rsp_t rsp_d, rsp_q;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      vld_q  <= start_i;
      done_q <= vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) req_q <= req_i;
    if (vld_q) rsp_q <= rsp_d;
  end

  fsif_decode u_dec (.req_i(req_q), .mid_o(mid));
  fsif_norm   u_norm (.mid_i(mid), .rsp_o(rsp_d));

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni) start_i |=> ##1 done_o)
    else $error("result missing");
  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(start_i, 2) |-> !done_o) else $error("spurious result");
  a_busy: assert property (@(posedge clk_i) !busy_o) else $error("busy asserted");
endmodule

// File: tb/sv/tb_float_split_integer_fraction.sv
// testbench: float integer/fraction splitter checked against a bit-exact split predictor
module tb_float_split_integer_fraction import fsif_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic FMT_SGL = 1'b0;
  localparam logic FMT_DBL = 1'b1;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start_i = 1'b0;
  fsif_req_t req_i = '0;
  logic      busy_o;
  logic      done_o;
  fsif_rsp_t rsp_o;

  fsif_rsp_t split_q[$];
  int        mismatches = 0;
  int        unexpected = 0;

  float_split_integer_fraction dut (
    .clk_i, .rst_ni, .start_i, .req_i, .busy_o, .done_o, .rsp_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] split_part(input logic [63:0] v, input int mb,
                                             input int emax, input int bias, input int sbit,
                                             output logic [63:0] frac);
    int          e;
    int          p;
    logic [63:0] mask;
    logic [63:0] r;
    logic [63:0] sign;
    logic [63:0] biased;
    e = int'((v >> mb) & 64'(emax)) - bias;
    sign = v & (64'd1 << sbit);
    if (e >= mb) begin
      frac = '0;
      return v;
    end
    if (e < 0) begin
      frac = v;
      return '0;
    end
    mask = (64'd1 << (mb - e)) - 64'd1;
    r = v & mask;
    if (r == '0) begin
      frac = '0;
      return v;
    end
    p = 0;
    for (int i = 0; i < 64; i++) if (r[i]) p = i;
    biased = 64'(p + e - mb + bias);
    frac = sign | (biased << mb) | ((r << (mb - p)) & ((64'd1 << mb) - 64'd1));
    return v & ~mask;
  endfunction

  function automatic fsif_rsp_t predict_split(input fsif_req_t rq);
    fsif_rsp_t   rs;
    logic [63:0] f;
    if (rq.req_type == FMT_DBL) begin
      rs.integer_part = split_part(rq.value_bits, DblMant, 'h7FF, int'(DblBias), 63, f);
      rs.fractional_part = f;
    end else begin
      rs.integer_part = split_part({32'd0, rq.value_bits[31:0]}, SglMant, 'hFF,
                                   int'(SglBias), 31, f) & 64'hFFFF_FFFF;
      rs.fractional_part = f & 64'hFFFF_FFFF;
    end
    return rs;
  endfunction

  task automatic send_request(input logic fmt, input logic [63:0] bits);
    fsif_req_t rq;
    int        gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      req_i <= {1'b0, {$urandom, $urandom}};
      repeat (gap) @(posedge clk_i);
    end
    rq.req_type = fmt;
    rq.value_bits = bits;
    start_i <= 1'b1;
    req_i <= rq;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    split_q.push_back(predict_split(rq));
  endtask

  // build a value with a chosen unbiased exponent and random mantissa
  function automatic logic [63:0] with_exp(input logic fmt, input int e);
    logic [63:0] v;
    v = {$urandom, $urandom};
    if (fmt == FMT_DBL) v[62:52] = 11'(e + 1023);
    else v[30:23] = 8'(e + 127);
    return v;
  endfunction

  always @(posedge clk_i) begin
    if (done_o) begin
      if (split_q.size() == 0) begin
        unexpected++;
        if (unexpected + mismatches <= 10) $display("unexpected result %h", rsp_o);
      end else begin
        fsif_rsp_t ex;
        ex = split_q.pop_front();
        if (rsp_o.integer_part !== ex.integer_part ||
            rsp_o.fractional_part !== ex.fractional_part) begin
          mismatches++;
          if (mismatches + unexpected <= 10)
            $display("mismatch exp int %h frac %h got int %h frac %h",
                     ex.integer_part, ex.fractional_part,
                     rsp_o.integer_part, rsp_o.fractional_part);
        end
      end
    end
  end

  task automatic test_special_values();
    send_request(FMT_SGL, 64'h0000_0000_0000_0000);
    send_request(FMT_SGL, 64'h0000_0000_8000_0000);
    send_request(FMT_SGL, 64'h0000_0000_7F80_0000);
    send_request(FMT_SGL, 64'h0000_0000_FFC0_0001);
    send_request(FMT_SGL, 64'h0000_0000_0000_0001);
    send_request(FMT_SGL, 64'hFFFF_FFFF_3FC0_0000);
    send_request(FMT_SGL, 64'h0000_0000_BFC0_0000);
    send_request(FMT_SGL, 64'h0000_0000_4040_0000);
    send_request(FMT_SGL, 64'h0000_0000_4B7F_FFFF);
    send_request(FMT_SGL, 64'h0000_0000_4AFF_FFFF);
    send_request(FMT_SGL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FMT_DBL, 64'h0000_0000_0000_0000);
    send_request(FMT_DBL, 64'h8000_0000_0000_0000);
    send_request(FMT_DBL, 64'h7FF0_0000_0000_0000);
    send_request(FMT_DBL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_request(FMT_DBL, 64'h0000_0000_0000_0001);
    send_request(FMT_DBL, 64'h3FF8_0000_0000_0000);
    send_request(FMT_DBL, 64'hC008_0000_0000_0000);
    send_request(FMT_DBL, 64'h4330_0000_0000_0000);
    send_request(FMT_DBL, 64'h432F_FFFF_FFFF_FFFF);
    send_request(FMT_DBL, 64'hBFEF_FFFF_FFFF_FFFF);
  endtask

  task automatic test_random_splits();
    logic fmt;
    int   k;
    for (int n = 0; n < 1350; n++) begin
      fmt = logic'($urandom_range(0, 1));
      k = $urandom_range(0, 9);
      if (k < 6) send_request(fmt, with_exp(fmt, (fmt == FMT_DBL) ?
                              $urandom_range(0, 51) : $urandom_range(0, 22)));
      else if (k < 8) send_request(fmt, with_exp(fmt, (fmt == FMT_DBL) ?
                                   $urandom_range(0, 60) - 8 : $urandom_range(0, 30) - 4));
      else send_request(fmt, {$urandom, $urandom});
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_special_values();
    test_random_splits();
    start_i <= 1'b0;
    while (split_q.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);
    if (mismatches == 0 && unexpected == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #500us;
    $display("status: fail");
    $finish;
  end

endmodule
